// File: sv/i2a_pkg.sv
// Shared types, codes and helper functions for the integer to ASCII formatter.
// No dependencies; every other file of the block imports this package.
package i2a_pkg;

   typedef enum logic [2:0] {
      ACT_HEX8   = 3'd0,
      ACT_HEX16  = 3'd1,
      ACT_UDEC8  = 3'd2,
      ACT_SDEC8  = 3'd3,
      ACT_UDEC16 = 3'd4,
      ACT_SDEC16 = 3'd5
   } action_type;

   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;   // 'A' - 10

   // first digit position: hex counts nibbles, decimal counts powers of ten
   localparam logic [2:0] POS_HEX8  = 3'd1;
   localparam logic [2:0] POS_HEX16 = 3'd3;
   localparam logic [2:0] POS_DEC8  = 3'd2;
   localparam logic [2:0] POS_DEC16 = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_payload_type;

   // one classified request, as passed from the front to the back
   typedef struct packed {
      logic        is_hex;
      logic        neg;
      logic [2:0]  first_pos;
      logic [15:0] mag;
   } job_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [3:0]  digit;
      logic [15:0] rem;
   } dec_step_type;

   function automatic logic [16:0] dec_weight(input logic [2:0] pos);
      logic [16:0] w;
      case (pos)
         3'd4:    w = 17'd10000;
         3'd3:    w = 17'd1000;
         3'd2:    w = 17'd100;
         3'd1:    w = 17'd10;
         default: w = 17'd1;
      endcase
      return w;
   endfunction

   // one decimal digit by compare against the multiples of the weight
   function automatic dec_step_type dec_step(input logic [15:0] mag, input logic [2:0] pos);
      logic [16:0]  w;
      logic [16:0]  mult;
      logic [16:0]  sub;
      dec_step_type r;
      w       = dec_weight(pos);
      sub     = '0;
      r.digit = '0;
      for (int k = 1; k <= 9; k++) begin
         mult = w * 17'(k);
         if ({1'b0, mag} >= mult) begin
            r.digit = 4'(k);
            sub     = mult;
         end
      end
      r.rem = mag - sub[15:0];
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib > 4'd9) begin
         c = {4'h0, nib} + HEX_ALPHA_BASE;
      end else begin
         c = {4'h0, nib} + CHAR_ZERO;
      end
      return c;
   endfunction

endpackage

// File: sv/integer_to_ascii_formatter_top.sv
// Integer to ASCII formatter: hex, unsigned and signed decimal text, one character per response.
// Depends on i2a_pkg, i2a_front, i2a_queue and i2a_back.
// Request to first character, sequencer idle: queue entry, sequencer state, response register,
// plus a step per leading zero skipped. Throughput: one digit position a cycle, at most one
// character, unless rsp_ready stalls; steps: 2 hex8, 4 hex16, 3 or 5 decimal, +1 minus, max 6.
// Reset (synchronous): empties the job queue, idles the sequencer and drops any held character.
module integer_to_ascii_formatter_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  i2a_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output i2a_pkg::rsp_payload_type rsp_payload
);
   import i2a_pkg::*;

   queue_status_type queue_status;
   job_type          front_job;
   job_type          head_job;
   logic             push;
   logic             pop;

   // classify the request and hand it on as a job; unused actions are dropped here
   i2a_front u_front (
      .req_valid    (req_valid),
      .req_payload  (req_payload),
      .queue_status (queue_status),
      .req_ready    (req_ready),
      .push         (push),
      .job          (front_job)
   );

   // hold up to two jobs so the front keeps taking requests while characters drain
   i2a_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (front_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   // step through digit positions and register each character for the response channel
   i2a_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

// File: sv/i2a_front.sv
// Front end: accepts requests, drops unused action codes, works out sign and magnitude.
// Depends on i2a_pkg.
module i2a_front (
   input  logic                     req_valid,
   input  i2a_pkg::req_payload_type req_payload,
   input  i2a_pkg::queue_status_type queue_status,
   output logic                     req_ready,
   output logic                     push,
   output i2a_pkg::job_type         job
);
   import i2a_pkg::*;

   logic       legal;
   logic [7:0] low_byte;

   assign low_byte  = req_payload.value[7:0];
   assign req_ready = !queue_status.full;

   always_comb begin
      legal         = 1'b1;
      job.is_hex    = 1'b0;
      job.neg       = 1'b0;
      job.first_pos = POS_DEC16;
      job.mag       = req_payload.value;
      case (action_type'(req_payload.action))
         ACT_HEX8: begin
            job.is_hex    = 1'b1;
            job.first_pos = POS_HEX8;
            job.mag       = {8'h00, low_byte};
         end
         ACT_HEX16: begin
            job.is_hex    = 1'b1;
            job.first_pos = POS_HEX16;
         end
         ACT_UDEC8: begin
            job.first_pos = POS_DEC8;
            job.mag       = {8'h00, low_byte};
         end
         ACT_SDEC8: begin
            job.first_pos = POS_DEC8;
            job.neg       = low_byte[7];
            // negation of 0x80 wraps to 0x80, which is the wanted magnitude
            job.mag       = low_byte[7] ? {8'h00, 8'(~low_byte + 8'd1)} : {8'h00, low_byte};
         end
         ACT_UDEC16: begin
            job.first_pos = POS_DEC16;
         end
         ACT_SDEC16: begin
            job.neg = req_payload.value[15];
            job.mag = req_payload.value[15] ? 16'(~req_payload.value + 16'd1)
                                            : req_payload.value;
         end
         default: begin
            legal = 1'b0;
         end
      endcase
   end

   // unused codes are taken and dropped
   assign push = req_valid && req_ready && legal;

endmodule

// File: sv/i2a_queue.sv
// Two-entry job queue between the front end and the character sequencer.
// Depends on i2a_pkg.
module i2a_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  i2a_pkg::job_type          push_job,
   input  logic                      pop,
   output i2a_pkg::job_type          head_job,
   output i2a_pkg::queue_status_type status
);
   import i2a_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full && !pop |-> !push)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.valid)
      else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

// File: sv/i2a_back.sv
// Character sequencer: one position a cycle unless stalled; registers the characters.
// Depends on i2a_pkg.
module i2a_back (
   input  logic                      clock,
   input  logic                      reset,
   input  i2a_pkg::queue_status_type queue_status,
   input  i2a_pkg::job_type          head_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output i2a_pkg::rsp_payload_type  rsp_payload
);
   import i2a_pkg::*;

   logic            active_ff, active_in;
   logic            sign_ff, sign_in;
   logic            started_ff, started_in;
   logic            is_hex_ff, is_hex_in;
   logic [2:0]      pos_ff, pos_in;
   logic [15:0]     mag_ff, mag_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   dec_step_type dstep;
   logic [3:0]   nibble;
   logic [7:0]   digit_char;
   logic         digit_nonzero;
   logic         emit_digit;
   logic         emit;
   logic         is_last;
   logic         out_free;
   logic         step;
   logic         done;
   logic         load;

   always_comb begin
      case (pos_ff[1:0])
         2'd3:    nibble = mag_ff[15:12];
         2'd2:    nibble = mag_ff[11:8];
         2'd1:    nibble = mag_ff[7:4];
         default: nibble = mag_ff[3:0];
      endcase
   end

   assign dstep         = dec_step(mag_ff, pos_ff);
   assign digit_char    = is_hex_ff ? hex_char(nibble) : ({4'h0, dstep.digit} + CHAR_ZERO);
   assign digit_nonzero = (dstep.digit != 4'd0);
   // decimal leading zeros are skipped; hex digits and the units digit always show
   assign emit_digit    = is_hex_ff || digit_nonzero || started_ff || (pos_ff == 3'd0);
   assign emit          = active_ff && (sign_ff || emit_digit);
   assign is_last       = !sign_ff && (pos_ff == 3'd0);
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign step          = active_ff && (!emit || out_free);
   assign done          = step && is_last;
   assign load          = queue_status.valid && (!active_ff || done);
   assign pop           = load;

   always_comb begin
      active_in  = active_ff;
      sign_in    = sign_ff;
      started_in = started_ff;
      is_hex_in  = is_hex_ff;
      pos_in     = pos_ff;
      mag_in     = mag_ff;
      if (load) begin
         active_in  = 1'b1;
         sign_in    = head_job.neg;
         started_in = 1'b0;
         is_hex_in  = head_job.is_hex;
         pos_in     = head_job.first_pos;
         mag_in     = head_job.mag;
      end else if (done) begin
         active_in = 1'b0;
      end else if (step) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            pos_in     = pos_ff - 3'd1;
            started_in = started_ff || digit_nonzero;
            if (!is_hex_ff) begin
               mag_in = dstep.rem;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (step && emit) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.character = sign_ff ? CHAR_MINUS : digit_char;
         rsp_payload_in.last      = is_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff        <= sign_in;
      started_ff     <= started_in;
      is_hex_ff      <= is_hex_in;
      pos_ff         <= pos_in;
      mag_ff         <= mag_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> pos_ff <= 3'd4)
      else $error("digit position out of range");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff && !is_hex_ff |-> {1'b0, mag_ff} < 17'(dec_weight(pos_ff) * 17'd10)
                                  || pos_ff == 3'd4)
      else $error("decimal remainder exceeds digit range");
   a_sign_first: assert property (@(posedge clock) disable iff (reset)
      active_ff && sign_ff |-> !started_ff)
      else $error("minus sign pending after digits began");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done && !load |=> !active_ff)
      else $error("sequencer still busy after last character");

endmodule
